[sv/subject_memory_table_lru_pinned_unit_macros.svh]
// Assertion macros for the subject memory table unit.
`ifndef SUBJECT_MEMORY_TABLE_LRU_PINNED_UNIT_MACROS_SVH
`define SUBJECT_MEMORY_TABLE_LRU_PINNED_UNIT_MACROS_SVH

// same-cycle implication, checked out of reset
`define SMT_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define SMT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[sv/smt_pkg.sv]
// Shared types and constants of the subject memory table.
package smt_pkg;

  localparam int SUBJ_W     = 58;
  localparam int CMD_W      = 3;
  localparam int NOW_W      = 32;
  localparam int COUNT_W    = 16;
  localparam int CAP_W      = 9;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  typedef enum logic [CMD_W-1:0] {
    CMD_NOTICE       = 3'd0,
    CMD_INVESTIGATED = 3'd1,
    CMD_FAILED       = 3'd2,
    CMD_QUERY        = 3'd3,
    CMD_CLEAR        = 3'd4
  } cmd_t;

  localparam logic [CFG_IDX_W-1:0] REG_CAPACITY       = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FAIL_WINDOW    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RECOVER_WINDOW = 2'd2;

  localparam logic [CAP_W-1:0]      CAP_RESET    = 9'd256;
  localparam logic [CFG_DATA_W-1:0] WINDOW_RESET = 32'd600;
  localparam logic [COUNT_W-1:0]    COUNT_MAX    = 16'hFFFF;

endpackage

[sv/smt_in_if.sv]
// Command channel: one command word per handshake.
interface smt_in_if
  import smt_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  cmd;
  logic [SUBJ_W-1:0] subject_id;
  logic [NOW_W-1:0]  now;

  modport source (output valid, cmd, subject_id, now, input ready);
  modport sink   (input valid, cmd, subject_id, now, output ready);
endinterface

[sv/smt_out_if.sv]
// Result channel: one result word per handshake.
interface smt_out_if
  import smt_pkg::*;
();
  logic               valid;
  logic               ready;
  logic               found;
  logic               is_suppressed;
  logic [COUNT_W-1:0] failure_count;
  logic [COUNT_W-1:0] investigation_count;
  logic               evicted;
  logic [SUBJ_W-1:0]  evicted_subject;

  modport source (output valid, found, is_suppressed, failure_count, investigation_count,
                  evicted, evicted_subject, input ready);
  modport sink   (input valid, found, is_suppressed, failure_count, investigation_count,
                  evicted, evicted_subject, output ready);
endinterface

[sv/smt_cfg_if.sv]
// Configuration write channel: register index and write data.
interface smt_cfg_if
  import smt_pkg::*;
();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

[sv/subject_memory_table_lru_pinned_unit.sv]
// A command is accepted in ST_IDLE, scanned over all used entries in ST_SCAN and resolved in
// ST_ACT, which writes the result register; no new command is taken until then. The
// table's single read port scans one entry per cycle.
// The result register lets the next command enter while a result waits.
// Reset (rst_n low, synchronous) empties the table and loads the register defaults;
// entry memory is not cleared, only the fill count.
`include "subject_memory_table_lru_pinned_unit_macros.svh"

module subject_memory_table_lru_pinned_unit
  import smt_pkg::*;
#(
  parameter int MAX_ENTRIES = 256,
  parameter int TIME_BITS   = 32
) (
  input  logic      clk,
  input  logic      rst_n,
  smt_in_if.sink    in_ch,
  smt_out_if.source out_ch,
  smt_cfg_if.sink   cfg_ch
);

  localparam int IDX_W  = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int USED_W = $clog2(MAX_ENTRIES + 1);
  localparam int CMP_W  = (USED_W > CAP_W) ? USED_W : CAP_W;
  localparam int WIN_W  = (TIME_BITS > CFG_DATA_W) ? TIME_BITS : CFG_DATA_W;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_ACT  = 3'b100
  } state_t;

  typedef struct packed {
    logic [SUBJ_W-1:0]    subject;
    logic [TIME_BITS-1:0] last_seen;
    logic [TIME_BITS-1:0] fail_time;
    logic                 fail_vld;
    logic [TIME_BITS-1:0] inv_time;
    logic                 inv_vld;
    logic [COUNT_W-1:0]   fail_cnt;
    logic [COUNT_W-1:0]   inv_cnt;
  } row_t;

  // event at t is inside window win of now (time going backwards counts as inside)
  function automatic logic in_window(input logic [TIME_BITS-1:0] tnow,
                                     input logic [TIME_BITS-1:0] t,
                                     input logic [CFG_DATA_W-1:0] win);
    logic [TIME_BITS-1:0] diff;
    diff = tnow - t;
    return (tnow < t) || (WIN_W'(diff) < WIN_W'(win));
  endfunction

  row_t mem [MAX_ENTRIES];

  state_t                state_r, state_nxt;
  logic [CMD_W-1:0]      cmd_r;
  logic [SUBJ_W-1:0]     id_r;
  logic [TIME_BITS-1:0]  now_r;
  logic [USED_W-1:0]     issue_r;
  logic                  rd_vld_r;
  logic [IDX_W-1:0]      rd_idx_r;
  row_t                  rd_row_r;
  logic                  hit_r;
  logic [IDX_W-1:0]      hit_idx_r;
  row_t                  hit_row_r;
  logic                  vic_any_r;
  logic [IDX_W-1:0]      vic_idx_r;
  logic                  vic_hot_r;
  logic [TIME_BITS-1:0]  vic_ls_r;
  logic [SUBJ_W-1:0]     vic_subj_r;
  logic [USED_W-1:0]     used_r, used_nxt;
  logic [CAP_W-1:0]      cap_r;
  logic [CFG_DATA_W-1:0] fail_win_r;
  logic [CFG_DATA_W-1:0] rec_win_r;

  logic                  out_valid_r;
  logic                  out_found_r;
  logic                  out_supp_r;
  logic [COUNT_W-1:0]    out_fcnt_r;
  logic [COUNT_W-1:0]    out_icnt_r;
  logic                  out_evicted_r;
  logic [SUBJ_W-1:0]     out_ev_subj_r;

  logic accept, rd_en, commit;
  logic hit_now, cur_hot, better;

  assign in_ch.ready  = (state_r == ST_IDLE);
  assign accept       = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready = 1'b1;
  assign rd_en        = (state_r == ST_SCAN) && (issue_r < used_r);
  assign commit       = (state_r == ST_ACT) && (!out_valid_r || out_ch.ready);

  // per-entry evaluation on the registered read word
  always_comb begin
    hit_now = rd_vld_r && (rd_row_r.subject == id_r);
    cur_hot = (rd_row_r.fail_vld && in_window(now_r, rd_row_r.fail_time, fail_win_r)) ||
              (rd_row_r.inv_vld && in_window(now_r, rd_row_r.inv_time, rec_win_r));
    better  = !vic_any_r || (vic_hot_r && !cur_hot) ||
              ((vic_hot_r == cur_hot) &&
               ((rd_row_r.last_seen < vic_ls_r) ||
                ((rd_row_r.last_seen == vic_ls_r) && (rd_row_r.subject < vic_subj_r))));
  end

  // command resolution at the end of the scan
  logic [CMP_W-1:0]   cap_x, max_x, cap_eff, used_x;
  row_t               fresh_row, wr_row;
  logic [IDX_W-1:0]   wr_idx;
  logic               wr_en, res_present, res_evicted, res_supp;
  logic [SUBJ_W-1:0]  res_ev_subj;

  always_comb begin
    cap_x   = CMP_W'(cap_r);
    max_x   = CMP_W'(MAX_ENTRIES);
    cap_eff = (cap_x < max_x) ? cap_x : max_x;
    used_x  = CMP_W'(used_r);

    fresh_row           = '0;
    fresh_row.subject   = id_r;
    fresh_row.last_seen = now_r;

    wr_en       = 1'b0;
    wr_idx      = hit_idx_r;
    wr_row      = hit_row_r;
    used_nxt    = used_r;
    res_present = hit_r;
    res_evicted = 1'b0;
    res_ev_subj = '0;

    case (cmd_r)
      CMD_NOTICE: begin
        if ((id_r != '0) && (cap_eff != '0)) begin
          res_present = 1'b1;
          wr_en       = 1'b1;
          if (hit_r) begin
            wr_row.last_seen = now_r;
          end else if (used_x < cap_eff) begin
            wr_idx   = used_r[IDX_W-1:0];
            wr_row   = fresh_row;
            used_nxt = used_r + 1'b1;
          end else begin
            wr_idx      = vic_idx_r;
            wr_row      = fresh_row;
            res_evicted = 1'b1;
            res_ev_subj = vic_subj_r;
          end
        end
      end
      CMD_INVESTIGATED: begin
        if (hit_r) begin
          wr_en           = 1'b1;
          wr_row.inv_time = now_r;
          wr_row.inv_vld  = 1'b1;
          if (hit_row_r.inv_cnt != COUNT_MAX) begin
            wr_row.inv_cnt = hit_row_r.inv_cnt + 1'b1;
          end
        end
      end
      CMD_FAILED: begin
        if (hit_r) begin
          wr_en            = 1'b1;
          wr_row.fail_time = now_r;
          wr_row.fail_vld  = 1'b1;
          if (hit_row_r.fail_cnt != COUNT_MAX) begin
            wr_row.fail_cnt = hit_row_r.fail_cnt + 1'b1;
          end
        end
      end
      CMD_CLEAR: begin
        used_nxt    = '0;
        res_present = 1'b0;
      end
      default: begin
      end
    endcase

    res_supp = res_present && wr_row.fail_vld &&
               in_window(now_r, wr_row.fail_time, fail_win_r);
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (accept) state_nxt = ST_SCAN;
      ST_SCAN: if (!rd_en && !rd_vld_r) state_nxt = ST_ACT;
      ST_ACT:  if (commit) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      rd_vld_r    <= 1'b0;
      issue_r     <= '0;
      hit_r       <= 1'b0;
      vic_any_r   <= 1'b0;
      used_r      <= '0;
      out_valid_r <= 1'b0;
      cap_r       <= CAP_RESET;
      fail_win_r  <= WINDOW_RESET;
      rec_win_r   <= WINDOW_RESET;
    end else begin
      state_r  <= state_nxt;
      rd_vld_r <= rd_en;
      if (accept) begin
        issue_r   <= '0;
        hit_r     <= 1'b0;
        vic_any_r <= 1'b0;
      end else begin
        if (rd_en) issue_r <= issue_r + 1'b1;
        if (hit_now) hit_r <= 1'b1;
        if (rd_vld_r && better) vic_any_r <= 1'b1;
      end
      if (commit) begin
        used_r      <= used_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_ch.valid) begin
        case (cfg_ch.index)
          REG_CAPACITY:       cap_r      <= cfg_ch.data[CAP_W-1:0];
          REG_FAIL_WINDOW:    fail_win_r <= cfg_ch.data;
          REG_RECOVER_WINDOW: rec_win_r  <= cfg_ch.data;
          default: begin
          end
        endcase
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r <= in_ch.cmd;
      id_r  <= in_ch.subject_id;
      now_r <= TIME_BITS'(in_ch.now);
    end
    rd_idx_r <= issue_r[IDX_W-1:0];
    if (hit_now && !hit_r) begin
      hit_idx_r <= rd_idx_r;
      hit_row_r <= rd_row_r;
    end
    if (rd_vld_r && better) begin
      vic_idx_r  <= rd_idx_r;
      vic_hot_r  <= cur_hot;
      vic_ls_r   <= rd_row_r.last_seen;
      vic_subj_r <= rd_row_r.subject;
    end
    if (commit) begin
      out_found_r   <= hit_r;
      out_supp_r    <= res_supp;
      out_fcnt_r    <= res_present ? wr_row.fail_cnt : '0;
      out_icnt_r    <= res_present ? wr_row.inv_cnt : '0;
      out_evicted_r <= res_evicted;
      out_ev_subj_r <= res_ev_subj;
    end
  end

  // entry memory: one read port for the scan, one write port at resolution
  always_ff @(posedge clk) begin
    if (rd_en) rd_row_r <= mem[issue_r[IDX_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (commit && wr_en) mem[wr_idx] <= wr_row;
  end

  assign out_ch.valid               = out_valid_r;
  assign out_ch.found               = out_found_r;
  assign out_ch.is_suppressed       = out_supp_r;
  assign out_ch.failure_count       = out_fcnt_r;
  assign out_ch.investigation_count = out_icnt_r;
  assign out_ch.evicted             = out_evicted_r;
  assign out_ch.evicted_subject     = out_ev_subj_r;

  `SMT_ASSERT_NEXT(a_used_step, 1'b1,
    (used_r == $past(used_r)) || (used_r == $past(used_r) + 1'b1) || (used_r == '0),
    "fill count moved by more than one entry")
  `SMT_ASSERT_NOW(a_evict_not_found, out_valid_r && out_evicted_r, !out_found_r,
    "eviction reported for a subject already present")
  `SMT_ASSERT_NOW(a_act_drained, state_r == ST_ACT, !rd_vld_r && !rd_en,
    "resolution started with a scan read in flight")
  `SMT_ASSERT_NOW(a_used_bound, 1'b1, used_r <= USED_W'(MAX_ENTRIES),
    "fill count beyond table depth")

endmodule
